[src/abtp_pkg.sv]
package abtp_pkg;

    // Fixed field widths
    localparam int TOKEN_W = 16;
    localparam int LOGIT_W = 32;

    // Defaults for the top-level parameters
    localparam int HISTORY_DEPTH_DEF = 128;
    localparam int VOCAB_MAX_DEF     = 65536;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Request kinds carried on s_tuser
    typedef enum logic {
        REQ_LOGIT = 1'b0,
        REQ_CLEAR = 1'b1
    } req_t;

    // Classification attached to every queued item
    typedef struct packed {
        logic is_clear;
        logic last;
        logic in_range;
    } entry_flags_t;

endpackage

[src/abtp_front.sv]
module abtp_front #(
    parameter int VOCAB_MAX = 65536
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // [31:0] logit
    input  logic                          s_tuser,   // [0] req_type
    input  logic                          s_tlast,
    input  logic                          init_busy,
    input  logic                          push_ready,
    output logic                          push_valid,
    output abtp_pkg::entry_flags_t        push_flags,
    output logic [$clog2(VOCAB_MAX+1)-1:0] push_idx,
    output logic signed [31:0]            push_logit
);
    import abtp_pkg::*;

    localparam int IDX_W = $clog2(VOCAB_MAX + 1);

    logic [IDX_W-1:0] elem_idx_reg;
    logic [IDX_W-1:0] elem_idx_next;
    logic             is_clear;
    logic             in_range;

    // Hold off input while the queue is full or the back part sweeps its ban table
    assign s_tready   = push_ready && !init_busy;
    assign push_valid = s_tvalid && s_tready;

    // Classify the incoming transaction
    always_comb begin
        is_clear = (req_t'(s_tuser) == REQ_CLEAR);
        in_range = (elem_idx_reg < IDX_W'(VOCAB_MAX));
        push_flags.is_clear = is_clear;
        push_flags.last     = s_tlast && !is_clear;
        push_flags.in_range = in_range && !is_clear;
        push_idx   = elem_idx_reg;
        push_logit = $signed(s_tdata);
    end

    // Advance the element counter, saturating at the vocabulary size; tlast or a clear resets it
    always_comb begin
        elem_idx_next = elem_idx_reg;
        if (push_valid) begin
            if (is_clear || s_tlast) begin
                elem_idx_next = '0;
            end else if (in_range) begin
                elem_idx_next = elem_idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elem_idx_reg <= '0;
        end else begin
            elem_idx_reg <= elem_idx_next;
        end
    end

endmodule

[src/abtp_fifo.sv]
module abtp_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         wr_valid,
    output logic         wr_ready,
    input  logic [W-1:0] wr_data,
    output logic         rd_valid,
    input  logic         rd_pop,
    output logic [W-1:0] rd_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_pop && rd_valid;

    // Store incoming entries
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

[src/abtp_back.sv]
module abtp_back #(
    parameter int HISTORY_DEPTH = 128,
    parameter int VOCAB_MAX     = 65536
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           head_valid,
    input  abtp_pkg::entry_flags_t         head_flags,
    input  logic [$clog2(VOCAB_MAX+1)-1:0] head_idx,
    input  logic signed [31:0]             head_logit,
    output logic                           head_pop,
    output logic                           init_busy,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,   // [15:0] next_token
    output logic                           m_tuser    // [0] history_full
);
    import abtp_pkg::*;

    localparam int IDX_W     = $clog2(VOCAB_MAX + 1);
    localparam int BAN_DEPTH = (VOCAB_MAX < (1 << TOKEN_W)) ? VOCAB_MAX : (1 << TOKEN_W);
    localparam int BAN_AW    = $clog2(BAN_DEPTH);
    localparam int HIST_AW   = $clog2(HISTORY_DEPTH);
    localparam int LEN_W     = $clog2(HISTORY_DEPTH + 1);

    typedef enum logic [4:0] {
        ST_INIT   = 5'b00001,
        ST_RUN    = 5'b00010,
        ST_UNBAN  = 5'b00100,
        ST_APPEND = 5'b01000,
        ST_BUILD  = 5'b10000
    } back_state_t;

    back_state_t state_reg, state_next;

    // Memories
    logic [TOKEN_W-1:0] hist_mem [HISTORY_DEPTH];
    logic               ban_mem  [BAN_DEPTH];

    // History bookkeeping
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [TOKEN_W-1:0] tok_a_reg, tok_a_next;
    logic [TOKEN_W-1:0] tok_b_reg, tok_b_next;
    logic               pend_clear_reg, pend_clear_next;
    logic [TOKEN_W-1:0] pick_reg;
    logic               hist_we;

    // Ban table sweep and history scan
    logic [BAN_AW-1:0]  init_ptr_reg, init_ptr_next;
    logic [LEN_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic               rd_issue;
    logic               rd_vld_reg;
    logic [TOKEN_W-1:0] hist_rd_reg;
    logic [TOKEN_W-1:0] win0_reg, win1_reg;
    logic [1:0]         win_cnt_reg, win_cnt_next;
    logic               scanning;
    logic               scan_done;
    logic               pair_hit;
    logic               ban_we;
    logic [BAN_AW-1:0]  ban_waddr;
    logic               ban_wdata;

    // Element pipeline
    logic               head_in_ban;
    logic               ban_rd_reg;
    logic               sb_vld_reg;
    entry_flags_t       sb_flags_reg;
    logic [IDX_W-1:0]   sb_idx_reg;
    logic signed [31:0] sb_logit_reg;
    logic               sb_inban_reg;
    logic               sb_ban;
    logic               sb_first;
    logic               sb_better;
    logic               sb_emit;
    logic [IDX_W-1:0]   sb_pick;

    // Running best
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic signed [31:0] best_score_reg, best_score_next;
    logic               best_ban_reg, best_ban_next;

    // Output register
    logic               out_vld_reg;
    logic [TOKEN_W-1:0] out_token_reg;
    logic               out_full_reg;

    assign init_busy = (state_reg == ST_INIT);
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = out_token_reg;
    assign m_tuser   = out_full_reg;

    // Pop an element; a final one also needs the output slot to be free
    assign head_pop = (state_reg == ST_RUN) && head_valid &&
                      (!head_flags.last || !out_vld_reg || m_tready);
    assign head_in_ban = (head_idx < IDX_W'(BAN_DEPTH));

    // Scan control shared by the unban and build passes
    assign scanning  = (state_reg == ST_UNBAN) || (state_reg == ST_BUILD);
    assign rd_issue  = scanning && (rd_ptr_reg != len_reg);
    assign scan_done = scanning && (rd_ptr_reg == len_reg) && !rd_vld_reg;
    assign pair_hit  = rd_vld_reg && (win_cnt_reg == 2'd2) &&
                       (win0_reg == tok_a_reg) && (win1_reg == tok_b_reg);
    assign hist_we   = (state_reg == ST_APPEND) && !pend_clear_reg &&
                       (len_reg < LEN_W'(HISTORY_DEPTH));

    // Ban table write: zero sweep after reset, then set or drop followers
    always_comb begin
        ban_we    = 1'b0;
        ban_waddr = init_ptr_reg;
        ban_wdata = 1'b0;
        if (state_reg == ST_INIT) begin
            ban_we = 1'b1;
        end else if (pair_hit) begin
            ban_we    = 1'b1;
            ban_waddr = hist_rd_reg[BAN_AW-1:0];
            ban_wdata = (state_reg == ST_BUILD);
        end
    end

    always_ff @(posedge aclk) begin
        if (ban_we) begin
            ban_mem[ban_waddr] <= ban_wdata;
        end
        if (head_pop && head_in_ban) begin
            ban_rd_reg <= ban_mem[head_idx[BAN_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[len_reg[HIST_AW-1:0]] <= pick_reg;
        end
        if (rd_issue) begin
            hist_rd_reg <= hist_mem[rd_ptr_reg[HIST_AW-1:0]];
        end
    end

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        len_next        = len_reg;
        tok_a_next      = tok_a_reg;
        tok_b_next      = tok_b_reg;
        pend_clear_next = pend_clear_reg;
        init_ptr_next   = init_ptr_reg;
        rd_ptr_next     = '0;
        win_cnt_next    = '0;
        if (scanning) begin
            rd_ptr_next  = rd_issue ? rd_ptr_reg + LEN_W'(1) : rd_ptr_reg;
            win_cnt_next = (rd_vld_reg && win_cnt_reg != 2'd2) ?
                           win_cnt_reg + 2'd1 : win_cnt_reg;
        end
        unique case (state_reg)
            ST_INIT: begin
                init_ptr_next = init_ptr_reg + BAN_AW'(1);
                if (init_ptr_reg == BAN_AW'(BAN_DEPTH - 1)) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (head_pop && (head_flags.last || head_flags.is_clear)) begin
                    pend_clear_next = head_flags.is_clear;
                    state_next      = ST_UNBAN;
                end
            end
            ST_UNBAN: begin
                if (scan_done) begin
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND: begin
                if (pend_clear_reg) begin
                    len_next = '0;
                end else if (hist_we) begin
                    len_next   = len_reg + LEN_W'(1);
                    tok_a_next = tok_b_reg;
                    tok_b_next = pick_reg;
                end
                state_next = ST_BUILD;
            end
            ST_BUILD: begin
                if (scan_done) begin
                    state_next = ST_RUN;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_INIT;
            len_reg        <= '0;
            pend_clear_reg <= 1'b0;
            init_ptr_reg   <= '0;
            rd_ptr_reg     <= '0;
            rd_vld_reg     <= 1'b0;
            win_cnt_reg    <= '0;
        end else begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            pend_clear_reg <= pend_clear_next;
            init_ptr_reg   <= init_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            rd_vld_reg     <= rd_issue;
            win_cnt_reg    <= win_cnt_next;
        end
    end

    // Slide the three-token window and hold the last pair
    always_ff @(posedge aclk) begin
        tok_a_reg <= tok_a_next;
        tok_b_reg <= tok_b_next;
        if (rd_vld_reg) begin
            win0_reg <= win1_reg;
            win1_reg <= hist_rd_reg;
        end
    end

    // Second element stage: compare against the running best
    always_comb begin
        sb_ban    = ban_rd_reg && sb_inban_reg;
        sb_first  = sb_vld_reg && sb_flags_reg.in_range && (sb_idx_reg == '0);
        sb_better = sb_vld_reg && sb_flags_reg.in_range && (sb_idx_reg != '0) && !sb_ban &&
                    (best_ban_reg || (sb_logit_reg > best_score_reg));
        sb_emit   = sb_vld_reg && sb_flags_reg.last;
        sb_pick   = (sb_first || sb_better) ? sb_idx_reg : best_idx_reg;

        best_idx_next   = best_idx_reg;
        best_score_next = best_score_reg;
        best_ban_next   = best_ban_reg;
        if (sb_first) begin
            best_idx_next   = '0;
            best_score_next = sb_logit_reg;
            best_ban_next   = sb_ban;
        end else if (sb_better) begin
            best_idx_next   = sb_idx_reg;
            best_score_next = sb_logit_reg;
            best_ban_next   = 1'b0;
        end
        // Drop the step at its end or on a clear request
        if (sb_vld_reg && (sb_flags_reg.last || sb_flags_reg.is_clear)) begin
            best_idx_next   = '0;
            best_score_next = '0;
            best_ban_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sb_vld_reg     <= 1'b0;
            best_idx_reg   <= '0;
            best_score_reg <= '0;
            best_ban_reg   <= 1'b0;
            out_vld_reg    <= 1'b0;
        end else begin
            sb_vld_reg     <= head_pop;
            best_idx_reg   <= best_idx_next;
            best_score_reg <= best_score_next;
            best_ban_reg   <= best_ban_next;
            if (sb_emit) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (head_pop) begin
            sb_flags_reg <= head_flags;
            sb_idx_reg   <= head_idx;
            sb_logit_reg <= head_logit;
            sb_inban_reg <= head_in_ban;
        end
        if (sb_emit) begin
            out_token_reg <= TOKEN_W'(sb_pick);
            out_full_reg  <= (len_reg == LEN_W'(HISTORY_DEPTH));
            pick_reg      <= TOKEN_W'(sb_pick);
        end
    end

endmodule

[src/argmax_trigram_block_picker.sv]
// Greedy argmax token picker with no-repeat-trigram blocking. Logits stream in on the s_ side,
// one transaction per vocabulary index starting at index 0, with tlast on the final one; the
// pick comes out on the m_ side with a history-full flag, and a transaction with tuser set
// clears the token history. Logits are taken at one per cycle while s_tready is high. After the
// final logit of a step, and after a clear, the back end rescans the token history twice (once
// to drop the old bans, once to mark the new ones) through the single history memory port; the
// input queue absorbs up to four transactions of the next step meanwhile. After reset the ban
// table, one bit per token value and min(VOCAB_MAX, 65536) entries deep, is swept to zero
// with s_tready held low.
module argmax_trigram_block_picker #(
    parameter int HISTORY_DEPTH = abtp_pkg::HISTORY_DEPTH_DEF,
    parameter int VOCAB_MAX     = abtp_pkg::VOCAB_MAX_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] logit
    input  logic        s_tuser,   // [0] req_type
    input  logic        s_tlast,   // last_logit
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] next_token
    output logic        m_tuser    // [0] history_full
);
    import abtp_pkg::*;

    localparam int IDX_W = $clog2(VOCAB_MAX + 1);
    localparam int ENT_W = IDX_W + LOGIT_W + $bits(entry_flags_t);

    logic               push_valid;
    logic               push_ready;
    entry_flags_t       push_flags;
    logic [IDX_W-1:0]   push_idx;
    logic signed [31:0] push_logit;
    logic               init_busy;
    logic               head_valid;
    logic               head_pop;
    logic [ENT_W-1:0]   head_data;
    entry_flags_t       head_flags;
    logic [IDX_W-1:0]   head_idx;
    logic signed [31:0] head_logit;

    abtp_front #(
        .VOCAB_MAX (VOCAB_MAX)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .init_busy  (init_busy),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_flags (push_flags),
        .push_idx   (push_idx),
        .push_logit (push_logit)
    );

    abtp_fifo #(
        .W     (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  ({push_idx, push_logit, push_flags}),
        .rd_valid (head_valid),
        .rd_pop   (head_pop),
        .rd_data  (head_data)
    );

    // Unpack the queue head
    assign head_flags = entry_flags_t'(head_data[$bits(entry_flags_t)-1:0]);
    assign head_logit = $signed(head_data[$bits(entry_flags_t) +: LOGIT_W]);
    assign head_idx   = head_data[ENT_W-1 -: IDX_W];

    abtp_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .VOCAB_MAX     (VOCAB_MAX)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_flags (head_flags),
        .head_idx   (head_idx),
        .head_logit (head_logit),
        .head_pop   (head_pop),
        .init_busy  (init_busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

[test/argmax_trigram_block_picker_checker.sv]
module argmax_trigram_block_picker_checker #(
    parameter int HISTORY_DEPTH = abtp_pkg::HISTORY_DEPTH_DEF,
    parameter int VOCAB_MAX     = abtp_pkg::VOCAB_MAX_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] logit
    input  logic        s_tuser,   // [0] req_type
    input  logic        s_tlast,   // last_logit
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [15:0] next_token
    input  logic        m_tuser,   // [0] history_full
    output int          fail_count,
    output int          pending_picks
);
    timeunit 1ns;
    timeprecision 1ps;

    import abtp_pkg::*;

    typedef struct packed {
        logic [TOKEN_W-1:0] token;
        logic               full;
    } pick_t;

    // Shadow of the generated sequence and of the step in progress
    logic [TOKEN_W-1:0]        seq_tokens [HISTORY_DEPTH];
    int                        seq_len;
    bit                        pair_hit [HISTORY_DEPTH];
    int                        elem_cnt;
    int                        lead_idx;
    logic signed [LOGIT_W-1:0] lead_score;
    bit                        lead_banned;
    pick_t                     pick_q [$];

    task automatic report_mismatch(input string msg);
        $display("%0t ns checker: %s", $time, msg);
        fail_count++;
    endtask

    task automatic restart_step();
        elem_cnt    = 0;
        lead_idx    = 0;
        lead_score  = '0;
        lead_banned = 1'b0;
    endtask

    // Mark every earlier position where the last two tokens occurred as a pair
    task automatic mark_pairs();
        logic [TOKEN_W-1:0] prev2;
        logic [TOKEN_W-1:0] prev1;
        for (int i = 0; i < HISTORY_DEPTH; i++) pair_hit[i] = 1'b0;
        if (seq_len < 2) return;
        prev2 = seq_tokens[seq_len-2];
        prev1 = seq_tokens[seq_len-1];
        for (int i = 0; i + 2 < seq_len; i++) begin
            if (seq_tokens[i] == prev2 && seq_tokens[i+1] == prev1) pair_hit[i] = 1'b1;
        end
    endtask

    function automatic bit trigram_banned(input int idx);
        if (seq_len < 2) return 1'b0;
        for (int i = 0; i + 2 < seq_len; i++) begin
            if (pair_hit[i] && int'(seq_tokens[i+2]) == idx) return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic take_clear();
        seq_len = 0;
        for (int i = 0; i < HISTORY_DEPTH; i++) pair_hit[i] = 1'b0;
        restart_step();
    endtask

    // Fold one logit into the running argmax; close the step on the flagged one
    task automatic take_element(input logic signed [LOGIT_W-1:0] score, input logic last);
        bit    banned;
        pick_t pick;
        if (elem_cnt == 0) mark_pairs();
        if (elem_cnt < VOCAB_MAX) begin
            banned = trigram_banned(elem_cnt);
            if (elem_cnt == 0) begin
                lead_idx    = 0;
                lead_score  = score;
                lead_banned = banned;
            end else if (!banned && (lead_banned || score > lead_score)) begin
                lead_idx    = elem_cnt;
                lead_score  = score;
                lead_banned = 1'b0;
            end
            elem_cnt++;
        end
        if (!last) return;
        pick.token = TOKEN_W'(lead_idx);
        pick.full  = (seq_len >= HISTORY_DEPTH);
        if (!pick.full) begin
            seq_tokens[seq_len] = pick.token;
            seq_len++;
        end
        pick_q = {pick_q, pick};
        restart_step();
    endtask

    task automatic compare_pick();
        pick_t want;
        if (pick_q.size() == 0) begin
            report_mismatch($sformatf("token %0d arrived with no pick pending", m_tdata));
            return;
        end
        want = pick_q.pop_front();
        if (m_tdata !== want.token)
            report_mismatch($sformatf("next_token %0d, predicted %0d", m_tdata, want.token));
        if (m_tuser !== want.full)
            report_mismatch($sformatf("history_full %b, predicted %b (token %0d)",
                                      m_tuser, want.full, want.token));
    endtask

    // Sample both channels at the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            seq_len    = 0;
            fail_count = 0;
            for (int i = 0; i < HISTORY_DEPTH; i++) pair_hit[i] = 1'b0;
            restart_step();
            pick_q.delete();
        end else begin
            if (m_tvalid && m_tready) compare_pick();
            if (s_tvalid && s_tready) begin
                if (s_tuser == REQ_CLEAR) take_clear();
                else take_element(s_tdata, s_tlast);
            end
        end
        pending_picks = pick_q.size();
    end

endmodule

[test/tb_argmax_trigram_block_picker.sv]
module tb_argmax_trigram_block_picker;
    timeunit 1ns;
    timeprecision 1ps;

    import abtp_pkg::*;

    localparam int          HIST_DEPTH     = HISTORY_DEPTH_DEF;
    localparam int          VOCAB          = VOCAB_MAX_DEF;
    localparam int          RANDOM_TXNS    = 1300;
    localparam int          RUN_LIMIT      = 2_000_000;
    localparam int          DRAIN_CYCLES   = 2 * HIST_DEPTH + 40;
    localparam int          RX_HOLD_CYCLES = 600;
    localparam logic [31:0] LOGIT_MIN      = 32'h8000_0000;
    localparam logic [31:0] LOGIT_MAX      = 32'h7FFF_FFFF;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [31:0] logit
    logic        s_tuser  = 1'b0; // [0] req_type
    logic        s_tlast  = 1'b0; // last_logit
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [15:0] next_token
    logic        m_tuser;         // [0] history_full

    int fail_count;
    int pending_picks;
    int cycle_count   = 0;
    int txn_count     = 0;
    int rx_hold_cycles = 0;
    bit tx_quiet      = 1'b0;
    bit rx_quiet      = 1'b0;

    always #5ns aclk = ~aclk;

    argmax_trigram_block_picker #(
        .HISTORY_DEPTH(HIST_DEPTH),
        .VOCAB_MAX    (VOCAB)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    argmax_trigram_block_picker_checker #(
        .HISTORY_DEPTH(HIST_DEPTH),
        .VOCAB_MAX    (VOCAB)
    ) u_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .pending_picks(pending_picks)
    );

    // Bound the run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offer one transaction after a random gap and hold it until accepted
    task automatic send_txn(input req_t req, input logic [31:0] logit, input logic last);
        int gap;
        if ($urandom_range(0, 63) == 0) tx_quiet = !tx_quiet;
        gap = tx_quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = req;
        s_tdata  = logit;
        s_tlast  = last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        txn_count++;
    endtask

    // Short step with up to three given logits
    task automatic send_vector(input int n, input logic [31:0] v0,
                               input logic [31:0] v1 = '0, input logic [31:0] v2 = '0);
        logic [31:0] vals [3];
        vals = '{v0, v1, v2};
        for (int i = 0; i < n; i++) send_txn(REQ_LOGIT, vals[i], i == n - 1);
    endtask

    // Mix of extremes, near-ties and full-range values
    function automatic logic [31:0] draw_logit();
        case ($urandom_range(0, 9))
            0:       return LOGIT_MIN;
            1:       return LOGIT_MAX;
            2, 3, 4: return 32'($urandom_range(0, 6)) - 32'd3;
            default: return $urandom;
        endcase
    endfunction

    // Mostly tiny vocabularies so picks repeat and trigrams get banned
    function automatic int draw_vocab();
        case ($urandom_range(0, 15))
            0:       return $urandom_range(7, 40);
            1:       return 1;
            default: return $urandom_range(2, 5);
        endcase
    endfunction

    task automatic send_step(input int vocab, input bit allow_clear);
        for (int i = 0; i < vocab; i++) begin
            if (allow_clear && $urandom_range(0, 149) == 0) begin
                // abandon the step partway with a clear
                send_txn(REQ_CLEAR, $urandom, 1'($urandom_range(0, 1)));
                return;
            end
            send_txn(REQ_LOGIT, draw_logit(), i == vocab - 1);
        end
    endtask

    // Result side: random stalls, quiet stretches, and one long hold-off on request
    initial begin : rx_side
        int stall;
        int hold_len;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (rx_hold_cycles > 0) begin
                hold_len       = rx_hold_cycles;
                rx_hold_cycles = 0;
                m_tready       = 1'b0;
                repeat (hold_len) @(negedge aclk);
            end
            if ($urandom_range(0, 63) == 0) rx_quiet = !rx_quiet;
            stall = rx_quiet ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    initial begin : stimulus
        int          seq;
        int          n_steps;
        int          base;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: clear with junk in the ignored fields
        send_txn(REQ_CLEAR, 32'hA5A5_5A5A, 1'b1);
        send_vector(3, LOGIT_MIN, LOGIT_MAX, LOGIT_MAX);   // tie keeps index 1
        send_vector(1, 32'd5);
        send_vector(2, 32'd0, 32'd9);                     // short history, no bans
        send_vector(2, 32'd3, 32'd2);
        send_vector(3, -32'd1, 32'd100, -32'd1);          // pair (1,0) repeats: 1 banned
        send_vector(1, 32'd4);
        send_vector(3, LOGIT_MAX, LOGIT_MIN, -32'd2);     // 0 banned: 1 takes over, 2 wins
        send_vector(1, 32'd0);
        send_vector(1, 32'd1);
        send_vector(1, 32'd7);                            // only index banned: answer 0
        send_vector(3, 32'd5, 32'd5, 32'd5);              // 0 and 2 banned
        // step cut short by a clear
        send_txn(REQ_LOGIT, LOGIT_MAX, 1'b0);
        send_txn(REQ_LOGIT, 32'd1, 1'b0);
        send_txn(REQ_CLEAR, 32'd0, 1'b0);

        // Hold off until the block has drained
        wait (pending_picks == 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        // Random sequences; the first one runs past history capacity
        base = txn_count;
        seq  = 0;
        while (txn_count - base < RANDOM_TXNS) begin
            if (seq == 1) rx_hold_cycles = RX_HOLD_CYCLES;
            send_txn(REQ_CLEAR, $urandom, 1'($urandom_range(0, 1)));
            if (seq == 0 || $urandom_range(0, 5) == 0)
                n_steps = $urandom_range(HIST_DEPTH + 2, HIST_DEPTH + 12);
            else
                n_steps = $urandom_range(3, 30);
            for (int s = 0; s < n_steps && txn_count - base < RANDOM_TXNS; s++)
                send_step(draw_vocab(), seq != 0);
            seq++;
        end
        s_tvalid = 1'b0;

        wait (pending_picks == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
